/* rtl/core/assert_macros.svh */
// Assertion macros shared by the pattern unpacker RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// ante true at an edge -> cons true at the same edge
`define TPU_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante true at an edge -> cons true at the next edge
`define TPU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TPU_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define TPU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* rtl/core/tpu_pkg.sv */
// Types and constants for the tracker pattern unpacker.
// No dependencies; used by tpu_cell_parser and the top level.
package tpu_pkg;

    localparam logic [7:0] LEAD_MASK_FLAG = 8'h80;
    localparam logic [4:0] FIELD_BITS     = 5'h1F;
    localparam logic [4:0] ALL_BUT_NOTE   = 5'h1E;
    localparam logic [7:0] NO_EFFECT_RESET = 8'hFF;

    // note sits in the low byte when packed
    typedef struct packed {
        logic [7:0] effect_param;
        logic [7:0] effect_type;
        logic [7:0] volume_column;
        logic [7:0] instrument_number;
        logic [7:0] note_value;
    } cell_t;

    typedef struct packed {
        logic [4:0] pending;
        cell_t      next_cell;
        logic       emit;
        cell_t      record;
    } parse_out_t;

endpackage

/* rtl/core/tracker_pattern_unpacker_core.sv */
// Top level of the tracker pattern unpacker: input register, parser
// state, result register. Depends on tpu_pkg, tpu_cell_parser, assert_macros.svh.
//
// channel   dir  handshake                   payload
// s_axis    in   s_axis_tvalid/tready        tdata: data_byte; tuser: pattern_start
// m_axis    out  m_axis_tvalid/tready        tdata: one note record (40 bits)
// cfg       in   cfg_we                      cfg_wdata: no_effect_code
//
// One byte per cycle sustained while m_axis is ready; a cell's last byte goes
// via the input and result registers to m_axis. Parsing is done in the cycle
// between the input register and the result register. rst_n clears both valid
// flags, the parser state and sets no_effect_code to 0xFF. A stall on m_axis
// holds the result; the input register then fills and s_axis_tready drops.
`include "assert_macros.svh"

module tracker_pattern_unpacker_core
    import tpu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] pattern_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] note_value, [15:8] instrument_number,
                                        // [23:16] volume_column, [31:24] effect_type,
                                        // [39:32] effect_param
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_start_reg;
    logic [4:0] pend_reg;
    cell_t      cell_reg;
    logic       out_valid_reg;
    cell_t      out_reg;
    logic [7:0] no_effect_reg;

    logic       process;
    parse_out_t parse;

    assign process       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || process;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    tpu_cell_parser u_parser
    (
        .pending        (pend_reg),
        .cur_cell       (cell_reg),
        .pattern_start  (in_start_reg),
        .data_byte      (in_byte_reg),
        .no_effect_code (no_effect_reg),
        .result         (parse)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            no_effect_reg <= NO_EFFECT_RESET;
        end
        else if (cfg_we)
        begin
            no_effect_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 5'd0;
            cell_reg      <= cell_t'(40'd0);
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (process)
            begin
                pend_reg      <= parse.pending;
                cell_reg      <= parse.next_cell;
                out_valid_reg <= parse.emit;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg  <= s_axis_tdata;
            in_start_reg <= s_axis_tuser;
        end
        if (process && parse.emit)
        begin
            out_reg <= parse.record;
        end
    end

    // zero type with zero param only leaves when the no-effect code is zero
    `TPU_ASSERT_SAME(a_fx_subst, clk, rst_n, m_axis_tvalid && m_axis_tdata[39:24] == 16'd0, no_effect_reg == 8'd0, "zero effect without zero no-effect code")
    // an unprocessed item stays in the input register
    `TPU_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid_reg && !process, in_valid_reg && $stable(in_byte_reg) && $stable(in_start_reg), "input item lost while stalled")
    // a stalled result is kept and not overwritten
    `TPU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid_reg && !m_axis_tready, out_valid_reg && $stable(out_reg), "result lost while stalled")
    // a pattern start always clears the partial cell
    `TPU_ASSERT_SAME(a_start_clear, clk, rst_n, process && in_start_reg && in_byte_reg[7] == 1'b0, parse.pending == ALL_BUT_NOTE && !parse.emit, "pattern start did not restart the cell")

endmodule

/* rtl/core/tpu_cell_parser.sv */
// Next-state logic of the cell parser: one byte in, updated state and
// an optional finished record out. Depends on tpu_pkg.
module tpu_cell_parser
    import tpu_pkg::*;
(
    input  logic [4:0] pending,
    input  cell_t      cur_cell,
    input  logic       pattern_start,
    input  logic [7:0] data_byte,
    input  logic [7:0] no_effect_code,
    output parse_out_t result
);

    logic [4:0] pend_in;
    logic [4:0] slot_sel;
    logic [4:0] pend_after;
    logic [39:0] cell_in;
    logic [39:0] cell_after;
    logic        done;
    cell_t       rec;

    always_comb
    begin
        pend_in  = pattern_start ? 5'd0 : pending;
        cell_in  = pattern_start ? 40'd0 : cur_cell;
        slot_sel = pend_in & (~pend_in + 5'd1);
        cell_after = cell_in;
        pend_after = pend_in;
        done = 1'b0;
        if (pend_in == 5'd0)
        begin
            cell_after = 40'd0;
            if ((data_byte & LEAD_MASK_FLAG) != 8'd0)
            begin
                pend_after = data_byte[4:0] & FIELD_BITS;
                done = (pend_after == 5'd0);
            end
            else
            begin
                cell_after[7:0] = data_byte;
                pend_after = ALL_BUT_NOTE;
            end
        end
        else
        begin
            for (int i = 0; i < 5; i++)
            begin
                if (slot_sel[i])
                begin
                    cell_after[i*8 +: 8] = data_byte;
                end
            end
            pend_after = pend_in & ~slot_sel;
            done = (pend_after == 5'd0);
        end

        rec = cell_t'(cell_after);
        if (rec.effect_type == 8'd0 && rec.effect_param == 8'd0)
        begin
            rec.effect_type = no_effect_code;
        end

        result.pending   = pend_after;
        result.next_cell = done ? cell_t'(40'd0) : cell_t'(cell_after);
        result.emit      = done;
        result.record    = rec;
    end

endmodule
